// ----- rtl/pse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants for the postfix stack evaluator
// Operation and status codes, payload structs and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package pse_pkg;

	localparam int DATA_W          = 32;
	localparam int DEPTH_W         = 8;
	localparam int OP_W            = 3;
	localparam int STAT_W          = 2;
	localparam int STACK_DEPTH_DEF = 128;

	localparam logic [DEPTH_W-1:0] CAP_RESET = 8'd128;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
	localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
	localparam logic [OP_W-1:0] OP_POP  = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [STAT_W-1:0] ST_DIVZERO   = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic signed [DATA_W-1:0] operand;
	} token_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] value;
		logic [DEPTH_W-1:0]       depth;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // take token, read second entry
		logic exec;        // finish a token that needs no divider run
		logic div_start;   // launch the divider
		logic div_finish;  // commit the quotient
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_needed;  // latched token is a valid divide
		logic div_done;    // divider quotient ready
	} dp_status_t;

endpackage

// ----- rtl/pse_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
	parameter int WIDTH = pse_pkg::DATA_W,
	parameter int DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/pse_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating
// toward zero. The quotient is valid from the done pulse until the next start.
// ----------------------------------------------------------------------------
module pse_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pse_pkg::DATA_W-1:0]  dividend,
	input  logic [pse_pkg::DATA_W-1:0]  divisor,
	output logic                        done,
	output logic [pse_pkg::DATA_W-1:0]  quotient
);
	import pse_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;
	logic [DATA_W+1:0] trial;
	logic [DATA_W-1:0] dvd_mag;
	logic [DATA_W-1:0] dvs_mag;

	// take magnitudes of the operands
	assign dvd_mag = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign dvs_mag = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;

	// trial subtract of the shifted remainder
	assign trial = {1'b0, rem_q, quo_q[DATA_W-1]} - {2'b00, dvs_q};

	// control: run for one step per quotient bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift dividend bits in, quotient bits out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dvd_mag;
			dvs_q <= dvs_mag;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (run_q) begin
			if (!trial[DATA_W+1]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// ----- rtl/pse_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_dp: evaluator datapath
// Stack store, top-of-stack register, depth counter, capacity register,
// arithmetic unit, divider and result register.
// ----------------------------------------------------------------------------
module pse_dp #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pse_pkg::token_t              token,
	input  pse_pkg::ctrl_cmd_t           cmd,
	output pse_pkg::dp_status_t          status,
	input  logic                         cfg_we,
	input  logic [pse_pkg::DEPTH_W-1:0]  cfg_data,
	output pse_pkg::result_t             result,
	output logic                         done
);
	import pse_pkg::*;

	localparam int AW        = $clog2(STACK_DEPTH);
	localparam int DepthClip = (STACK_DEPTH < 255) ? STACK_DEPTH : 255;
	localparam logic [DEPTH_W-1:0] DEPTH_LIM = DEPTH_W'(DepthClip);

	logic [OP_W-1:0]    op_q;
	logic [DATA_W-1:0]  opnd_q;
	logic [DATA_W-1:0]  top_q;
	logic [DEPTH_W-1:0] count_q;
	logic [DEPTH_W-1:0] cap_q;
	result_t            res_q;
	logic               done_q;

	logic [DATA_W-1:0]  second;
	logic [DATA_W-1:0]  quotient;
	logic               div_done;
	logic [DATA_W-1:0]  arith;
	logic [DEPTH_W-1:0] limit;
	logic               two_ok;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [DATA_W-1:0]  wr_data;
	logic               upd;
	logic [DEPTH_W-1:0] nxt_count;
	logic [DATA_W-1:0]  nxt_top;
	result_t            res_d;

	// stack store; entry below the top is read at load
	pse_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (cmd.load),
		.raddr (AW'(count_q - 8'd2)),
		.rdata (second)
	);

	pse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (second),
		.divisor  (top_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign limit  = (cap_q < DEPTH_LIM) ? cap_q : DEPTH_LIM;
	assign two_ok = (count_q >= 8'd2);

	assign status.div_needed = (op_q == OP_DIV) && two_ok && (top_q != '0);
	assign status.div_done   = div_done;

	// select the operator result
	always_comb begin
		case (op_q)
			OP_ADD:  arith = second + top_q;
			OP_SUB:  arith = second - top_q;
			OP_MUL:  arith = second * top_q;
			default: arith = quotient;
		endcase
	end

	// decide stack update and result
	always_comb begin
		wr_en        = 1'b0;
		wr_addr      = AW'(count_q - 8'd2);
		wr_data      = arith;
		upd          = 1'b0;
		nxt_count    = count_q;
		nxt_top      = top_q;
		res_d.status = ST_OK;
		res_d.value  = '0;
		res_d.depth  = count_q;
		if (cmd.div_finish) begin
			wr_en       = 1'b1;
			upd         = 1'b1;
			nxt_count   = count_q - 8'd1;
			nxt_top     = arith;
			res_d.value = arith;
			res_d.depth = count_q - 8'd1;
		end else if (cmd.exec) begin
			case (op_q)
				OP_PUSH: begin
					if (count_q >= limit) begin
						res_d.status = ST_OVERFLOW;
					end else begin
						wr_en       = 1'b1;
						wr_addr     = AW'(count_q);
						wr_data     = opnd_q;
						upd         = 1'b1;
						nxt_count   = count_q + 8'd1;
						nxt_top     = opnd_q;
						res_d.value = opnd_q;
						res_d.depth = count_q + 8'd1;
					end
				end
				OP_ADD, OP_SUB, OP_MUL: begin
					if (!two_ok) begin
						res_d.status = ST_UNDERFLOW;
					end else begin
						wr_en       = 1'b1;
						upd         = 1'b1;
						nxt_count   = count_q - 8'd1;
						nxt_top     = arith;
						res_d.value = arith;
						res_d.depth = count_q - 8'd1;
					end
				end
				OP_DIV: begin
					if (!two_ok) begin
						res_d.status = ST_UNDERFLOW;
					end else begin
						res_d.status = ST_DIVZERO;
					end
				end
				OP_POP: begin
					if (count_q == '0) begin
						res_d.status = ST_UNDERFLOW;
					end else begin
						upd         = 1'b1;
						nxt_count   = count_q - 8'd1;
						nxt_top     = second;
						res_d.value = top_q;
						res_d.depth = count_q - 8'd1;
					end
				end
				default: begin
					res_d.status = ST_OK;
				end
			endcase
		end
	end

	// control registers: depth, capacity, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec || cmd.div_finish;
			if (upd) begin
				count_q <= nxt_count;
			end
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= token.operation;
			opnd_q <= token.operand;
		end
		if (upd) begin
			top_q <= nxt_top;
		end
		if (cmd.exec || cmd.div_finish) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;
	assign done   = done_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_LIM)
		else $error("stack depth beyond limit");

	a_done_follows_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.div_finish) |=> done_q)
		else $error("result beat missing after commit");

	a_depth_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (res_q.depth == count_q))
		else $error("reported depth differs from stack count");

endmodule

// ----- rtl/pse_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_ctrl: evaluator controller
// Sequences token load, execute and the divider wait.
// ----------------------------------------------------------------------------
module pse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  pse_pkg::dp_status_t  status,
	output pse_pkg::ctrl_cmd_t   cmd,
	output logic                 busy
);
	import pse_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		state_d        = state_q;
		cmd.load       = 1'b0;
		cmd.exec       = 1'b0;
		cmd.div_start  = 1'b0;
		cmd.div_finish = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (status.div_needed) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_DIV: begin
				if (status.div_done) begin
					cmd.div_finish = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == S_DIV))
		else $error("divider finished outside divide wait");

endmodule

// ----- rtl/postfix_stack_evaluator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: RPN integer evaluator on a bounded stack
// Tokens push, pop or combine the two top entries; every token yields one
// result beat with status, value and depth.
// ----------------------------------------------------------------------------
//  channel   signals                       handshake
//  -------   ----------------------------  ---------------------------------
//  token     start, busy, token            beat when start && !busy
//  result    done, result                  one-cycle strobe, never stalled
//  config    cfg_valid, cfg_ready, cfg_data  beat when cfg_valid && cfg_ready
//
//  Push, add, subtract, multiply, pop and error tokens: busy is high for the
//  one execute cycle after the load cycle.
//  Divide: busy stays high until the one-bit-per-cycle divider (32 steps) is done and committed.
//  The result strobe comes the cycle after execute or divide commit; the receiver cannot stall.
//  Reset empties the stack and sets capacity to 128; no clearing pass.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  pse_pkg::token_t              token,
	output logic                         done,
	output pse_pkg::result_t             result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pse_pkg::DEPTH_W-1:0]  cfg_data
);
	import pse_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	pse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	pse_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.token    (token),
		.cmd      (cmd),
		.status   (status),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.result   (result),
		.done     (done)
	);

	// capacity register takes a write in any cycle
	assign cfg_ready = 1'b1;

endmodule
